@@ rtl/clc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clc_pkg: shared types and constants of the current level classifier
// Status codes, register indexes, reset values and width helpers used by
// the front, queue, back and top level of the classifier.
// ----------------------------------------------------------------------------
package clc_pkg;

    // Field widths fixed by the stream format.
    localparam int SAMPLE_W   = 16;
    localparam int CUR_W      = 16;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int TDATA_IN_W = 16;
    localparam int TDATA_OUT_W = 8;

    // Default batch limits.
    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int TOP_COUNT_DEF   = 3;
    localparam int QUEUE_DEPTH     = 2;

    // Register reset values.
    localparam logic [CUR_W-1:0] RATED_RESET = 16'd1000;
    localparam logic [CUR_W-1:0] MINW_RESET  = 16'd200;

    // Decision constants: overcurrent at OVER_DEN/OVER_NUM of rated, off limit in mA.
    localparam int OFF_LIMIT_MA = 100;
    localparam int OVER_NUM     = 5;
    localparam int OVER_DEN     = 4;

    // Decision modes.
    localparam logic MODE_PEAK = 1'b0;
    localparam logic MODE_MEAN = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_NORMAL  = 3'd0,
        ST_OVER    = 3'd1,
        ST_UNDER   = 3'd2,
        ST_OFF     = 3'd3,
        ST_INVALID = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATED = 2'd0,
        CFG_MINW  = 2'd1,
        CFG_MODE  = 2'd2
    } cfg_index_t;

    // Width of a sample counter that can hold max_samples itself.
    function automatic int cnt_width(int max_samples);
        return $clog2(max_samples + 1);
    endfunction

    // Width of a sum of up to max_samples magnitudes of at most 2^15.
    function automatic int sum_width(int max_samples);
        return cnt_width(max_samples) + SAMPLE_W - 1;
    endfunction

    // Width of one batch summary passed from front to back.
    function automatic int entry_width(int max_samples, int top_count);
        return sum_width(max_samples) + cnt_width(max_samples) + top_count * SAMPLE_W;
    endfunction

    // Magnitude of a signed sample; the most negative value maps to 2^15.
    function automatic logic [SAMPLE_W-1:0] mag16(logic signed [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] neg;
        neg = SAMPLE_W'(-v);
        return v[SAMPLE_W-1] ? neg : SAMPLE_W'(v);
    endfunction

endpackage

@@ rtl/clc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clc_front: batch accumulator
// Accepts sample beats, keeps the running sample count, magnitude sum and
// ranking of the largest samples, and hands a summary of each finished batch
// to the queue.
// ----------------------------------------------------------------------------
module clc_front #(
    parameter int MAX_SAMPLES = clc_pkg::MAX_SAMPLES_DEF,
    parameter int TOP_COUNT   = clc_pkg::TOP_COUNT_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [clc_pkg::TDATA_IN_W-1:0]          s_tdata,   // [15:0] sample_ma
    input  logic                                    s_tuser,   // [0] has_sample
    input  logic                                    s_tlast,
    output logic                                    q_valid,
    input  logic                                    q_ready,
    output logic [clc_pkg::entry_width(MAX_SAMPLES, TOP_COUNT)-1:0] q_data
);
    import clc_pkg::*;

    localparam int CNT_W = cnt_width(MAX_SAMPLES);
    localparam int SUM_W = sum_width(MAX_SAMPLES);

    logic signed [SAMPLE_W-1:0] top_reg  [TOP_COUNT];
    logic signed [SAMPLE_W-1:0] top_next [TOP_COUNT];
    logic signed [SAMPLE_W-1:0] prev     [TOP_COUNT];
    logic [TOP_COUNT-1:0]       ge;
    logic [TOP_COUNT-1:0]       ge_ext;
    logic [TOP_COUNT*SAMPLE_W-1:0] top_flat;
    logic [CNT_W-1:0]           cnt_reg, cnt_next, cnt_upd;
    logic [SUM_W-1:0]           sum_reg, sum_next, sum_upd;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       take;
    logic                       add;

    assign sample   = signed'(s_tdata[SAMPLE_W-1:0]);
    assign s_tready = q_ready;
    assign take     = s_tvalid && s_tready;
    assign add      = s_tuser && (cnt_reg < CNT_W'(MAX_SAMPLES));

    // Insertion into the descending ranking: equal samples stay ahead of the new one.
    always_comb begin
        ge_ext[0] = 1'b1;
        prev[0]   = sample;
        for (int i = 1; i < TOP_COUNT; i++) begin
            prev[i] = top_reg[i-1];
        end
        for (int i = 0; i < TOP_COUNT; i++) begin
            ge[i] = (int'(cnt_reg) > i) && (top_reg[i] >= sample);
        end
        for (int i = 1; i < TOP_COUNT; i++) begin
            ge_ext[i] = ge[i-1];
        end
        for (int i = 0; i < TOP_COUNT; i++) begin
            if (!add || ge[i]) begin
                top_next[i] = top_reg[i];
            end else if (ge_ext[i]) begin
                top_next[i] = sample;
            end else begin
                top_next[i] = prev[i];
            end
            top_flat[i*SAMPLE_W +: SAMPLE_W] = top_next[i];
        end
    end

    // Count and sum, cleared once the batch summary has been handed over.
    always_comb begin
        cnt_upd  = add ? cnt_reg + 1'b1 : cnt_reg;
        sum_upd  = add ? sum_reg + SUM_W'(mag16(sample)) : sum_reg;
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        if (take) begin
            cnt_next = s_tlast ? '0 : cnt_upd;
            sum_next = s_tlast ? '0 : sum_upd;
        end
    end

    assign q_valid = take && s_tlast;
    assign q_data  = {sum_upd, cnt_upd, top_flat};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            sum_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
        end
    end

    // Ranking entries beyond the fill level are never read, so they need no reset.
    always_ff @(posedge aclk) begin
        if (take) begin
            top_reg <= top_next;
        end
    end

endmodule

@@ rtl/clc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clc_queue: short batch summary queue
// A small register queue that lets the accumulator and the decision
// pipeline stall independently of each other.
// ----------------------------------------------------------------------------
module clc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = clc_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import clc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill level update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ rtl/clc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clc_back: status decision pipeline
// Stage one forms the peak magnitude sum and the products of counts with the
// configured currents; stage two compares them and holds the status beat.
// ----------------------------------------------------------------------------
module clc_back #(
    parameter int MAX_SAMPLES = clc_pkg::MAX_SAMPLES_DEF,
    parameter int TOP_COUNT   = clc_pkg::TOP_COUNT_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    q_valid,
    output logic                                    q_ready,
    input  logic [clc_pkg::entry_width(MAX_SAMPLES, TOP_COUNT)-1:0] q_data,
    input  logic [clc_pkg::CUR_W-1:0]               rated_ma,
    input  logic [clc_pkg::CUR_W-1:0]               minw_ma,
    input  logic                                    decision_mode,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output clc_pkg::status_t                        status
);
    import clc_pkg::*;

    localparam int CNT_W = cnt_width(MAX_SAMPLES);
    localparam int SUM_W = sum_width(MAX_SAMPLES);
    localparam int K_W   = $clog2(TOP_COUNT + 1);
    localparam int TS_W  = K_W + SAMPLE_W - 1;
    localparam int KR_W  = K_W + CUR_W;
    localparam int KO_W  = K_W + $clog2(OFF_LIMIT_MA + 1);
    localparam int NR_W  = CNT_W + CUR_W;
    localparam int PW    = TS_W + 3;
    localparam int TOP_LSB = 0;
    localparam int CNT_LSB = TOP_COUNT * SAMPLE_W;
    localparam int SUM_LSB = CNT_LSB + CNT_W;

    logic [CNT_W-1:0] in_cnt;
    logic [SUM_W-1:0] in_sum;
    logic [K_W-1:0]   k;
    logic [TS_W-1:0]  tsum;
    logic             a_load, b_adv;

    logic             a_valid_reg, a_valid_next;
    logic             a_n_zero_reg, a_rated_zero_reg;
    logic [TS_W-1:0]  a_tsum_reg;
    logic [KR_W-1:0]  a_kr_reg, a_kminw_reg;
    logic [KO_W-1:0]  a_koff_reg;
    logic [SUM_W-1:0] a_sum_reg;
    logic [NR_W-1:0]  a_nr_reg, a_nminw_reg;

    logic             out_valid_reg, out_valid_next;
    status_t          status_reg, status_next;
    logic [PW-1:0]    over_lhs, over_rhs;

    assign b_adv   = !out_valid_reg || out_ready;
    assign a_load  = !a_valid_reg || b_adv;
    assign q_ready = a_load;

    assign in_cnt = q_data[CNT_LSB +: CNT_W];
    assign in_sum = q_data[SUM_LSB +: SUM_W];

    // Number of ranked samples in use and the sum of their magnitudes.
    always_comb begin
        k    = K_W'((int'(in_cnt) < TOP_COUNT) ? int'(in_cnt) : TOP_COUNT);
        tsum = '0;
        for (int i = 0; i < TOP_COUNT; i++) begin
            if (i < int'(k)) begin
                tsum = tsum + TS_W'(mag16(signed'(q_data[TOP_LSB + i*SAMPLE_W +: SAMPLE_W])));
            end
        end
    end

    assign a_valid_next = a_load ? q_valid : a_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    // Stage one: sums and products.
    always_ff @(posedge aclk) begin
        if (q_valid && a_load) begin
            a_n_zero_reg     <= (in_cnt == '0);
            a_rated_zero_reg <= (rated_ma == '0);
            a_tsum_reg       <= tsum;
            a_kr_reg         <= KR_W'(k) * KR_W'(rated_ma);
            a_kminw_reg      <= KR_W'(k) * KR_W'(minw_ma);
            a_koff_reg       <= KO_W'(k) * KO_W'(OFF_LIMIT_MA);
            a_sum_reg        <= in_sum;
            a_nr_reg         <= NR_W'(in_cnt) * NR_W'(rated_ma);
            a_nminw_reg      <= NR_W'(in_cnt) * NR_W'(minw_ma);
        end
    end

    // Stage two: cross-multiplied comparisons.
    always_comb begin
        over_lhs = PW'(a_tsum_reg) * PW'(OVER_NUM);
        over_rhs = PW'(a_kr_reg) * PW'(OVER_DEN);
        if (decision_mode == MODE_PEAK) begin
            if (a_rated_zero_reg || a_n_zero_reg) begin
                status_next = ST_INVALID;
            end else if (over_lhs >= over_rhs) begin
                status_next = ST_OVER;
            end else if (a_tsum_reg <= TS_W'(a_koff_reg)) begin
                status_next = ST_OFF;
            end else if (KR_W'(a_tsum_reg) < a_kminw_reg) begin
                status_next = ST_UNDER;
            end else begin
                status_next = ST_NORMAL;
            end
        end else begin
            if (a_n_zero_reg) begin
                status_next = ST_INVALID;
            end else if (NR_W'(a_sum_reg) >= a_nr_reg) begin
                status_next = ST_OVER;
            end else if (NR_W'(a_sum_reg) >= a_nminw_reg) begin
                status_next = ST_NORMAL;
            end else begin
                status_next = ST_UNDER;
            end
        end
    end

    assign out_valid_next = b_adv ? a_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_valid_reg && b_adv) begin
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;

endmodule

@@ rtl/current_level_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// current_level_classifier: pump current status from batches of samples
// Sample beats come in on the s_ channel; one status beat per batch leaves on
// the m_ channel; thresholds and the mode are set through the cfg_ channel.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one signed sample in mA per beat, s_tuser marks a real sample,
//   s_tlast ends the batch. Beats are taken at one per cycle while s_tready is high.
//   m_ channel: one status beat for each beat with s_tlast set, in order.
//   The edge that takes the last beat writes the summary into the queue;
//   from there it loads the product stage and then the output register,
//   which shows the status. While m_tready is high, a new batch result
//   can follow every cycle.
//   cfg_ channel: always ready; write only while no batch is in flight.
//   Reset clears the running count, sum and all pending results, and loads
//   rated current 1000 mA, minimum working current 200 mA and peak mode.
//   When the receiver holds m_tready low the status beat stays put, the two
//   pipeline stages and the two-entry summary queue fill, and then s_tready
//   falls until room opens again.
// ----------------------------------------------------------------------------
module current_level_classifier #(
    parameter int MAX_SAMPLES = clc_pkg::MAX_SAMPLES_DEF,
    parameter int TOP_COUNT   = clc_pkg::TOP_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [clc_pkg::TDATA_IN_W-1:0]    s_tdata,   // [15:0] sample_ma
    input  logic                              s_tuser,   // [0] has_sample
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [clc_pkg::TDATA_OUT_W-1:0]   m_tdata,   // [2:0] pump_status, [7:3] zero
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [clc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [clc_pkg::CUR_W-1:0]         cfg_data
);
    import clc_pkg::*;

    localparam int ENTRY_W = entry_width(MAX_SAMPLES, TOP_COUNT);

    logic [CUR_W-1:0]   rated_reg, rated_next;
    logic [CUR_W-1:0]   minw_reg, minw_next;
    logic               mode_reg, mode_next;
    logic               fq_valid, fq_ready;
    logic [ENTRY_W-1:0] fq_data;
    logic               qb_valid, qb_ready;
    logic [ENTRY_W-1:0] qb_data;
    status_t            status;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_comb begin
        rated_next = rated_reg;
        minw_next  = minw_reg;
        mode_next  = mode_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_RATED: rated_next = cfg_data;
                CFG_MINW:  minw_next  = cfg_data;
                CFG_MODE:  mode_next  = cfg_data[0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rated_reg <= RATED_RESET;
            minw_reg  <= MINW_RESET;
            mode_reg  <= MODE_PEAK;
        end else begin
            rated_reg <= rated_next;
            minw_reg  <= minw_next;
            mode_reg  <= mode_next;
        end
    end

    // Accumulator, summary queue and decision pipeline.
    clc_front #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .TOP_COUNT  (TOP_COUNT)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    clc_queue #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fq_valid),
        .in_ready (fq_ready),
        .in_data  (fq_data),
        .out_valid(qb_valid),
        .out_ready(qb_ready),
        .out_data (qb_data)
    );

    clc_back #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .TOP_COUNT  (TOP_COUNT)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (qb_valid),
        .q_ready      (qb_ready),
        .q_data       (qb_data),
        .rated_ma     (rated_reg),
        .minw_ma      (minw_reg),
        .decision_mode(mode_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .status       (status)
    );

    assign m_tdata = {{(TDATA_OUT_W - STATUS_W){1'b0}}, status};

    // Peak mode with zero rated current can only report invalid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && mode_reg == MODE_PEAK && rated_reg == '0) |-> (status == ST_INVALID))
        else $error("peak mode with zero rated current gave a status other than invalid");

    // Mean mode with zero rated current gives overcurrent or invalid only.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && mode_reg == MODE_MEAN && rated_reg == '0)
            |-> (status == ST_OVER || status == ST_INVALID))
        else $error("mean mode with zero rated current gave an unexpected status");

    // The off status is a peak mode decision only.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && mode_reg == MODE_MEAN) |-> (status != ST_OFF))
        else $error("mean mode reported off");

    // A last beat is only refused while the summary queue is full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tlast && !s_tready) |-> !fq_ready)
        else $error("last beat refused while the queue had room");

endmodule

@@ tb/current_level_classifier_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// current_level_classifier_tb: self-checking bench for the classifier
// Drives sample beats with random gaps, keeps its own running model of the
// top samples, count and magnitude sum, and checks every status beat against
// the expected status. Threshold boundaries, register extremes, the full
// batch limit, output back-pressure and random batches are covered in turn.
// ----------------------------------------------------------------------------
module current_level_classifier_tb;
    import clc_pkg::*;

    localparam int MAX_SAMPLES = MAX_SAMPLES_DEF;
    localparam int TOP_COUNT   = TOP_COUNT_DEF;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_WAIT  = 8;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [TDATA_IN_W-1:0]    s_tdata;   // [15:0] sample_ma
    logic                     s_tuser;   // [0] has_sample
    logic                     s_tlast;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [TDATA_OUT_W-1:0]   m_tdata;   // [2:0] pump_status, [7:3] zero
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CUR_W-1:0]         cfg_data;

    // Register copies used by the status predictor.
    logic [CUR_W-1:0]         rated_ma;
    logic [CUR_W-1:0]         min_work_ma;
    logic                     mode_sel;

    // Running batch state of the predictor.
    logic signed [SAMPLE_W-1:0] top_vals [TOP_COUNT];
    int unsigned              batch_count;
    longint unsigned          batch_mag_sum;

    status_t                  expected_status [$];
    int                       fail_count;
    bit                       steady_run;
    bit                       hold_req;

    current_level_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    always #5 aclk = ~aclk;

    // Magnitude of a signed sample; the most negative value gives 32768.
    function automatic longint unsigned magnitude(logic signed [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] neg;
        neg = ~v + 16'd1;
        return v[SAMPLE_W-1] ? longint'(neg) : longint'(v);
    endfunction

    // Insert a sample into the descending list of the largest samples.
    function automatic void rank_sample(logic signed [SAMPLE_W-1:0] s);
        int pos;
        int filled;
        filled = (batch_count < TOP_COUNT) ? batch_count : TOP_COUNT;
        if (filled == TOP_COUNT) begin
            if (s <= top_vals[TOP_COUNT-1])
                return;
            pos = TOP_COUNT - 1;
        end else begin
            pos = filled;
        end
        while (pos > 0 && top_vals[pos-1] < s) begin
            top_vals[pos] = top_vals[pos-1];
            pos--;
        end
        top_vals[pos] = s;
    endfunction

    // Status of the batch collected so far, by exact cross-multiplication.
    function automatic status_t batch_status();
        longint unsigned n;
        longint unsigned k;
        longint unsigned peak_sum;
        longint unsigned rated;
        longint unsigned minw;
        n = batch_count;
        rated = rated_ma;
        minw = min_work_ma;
        peak_sum = 0;
        if (mode_sel == MODE_PEAK) begin
            if (rated == 0 || n == 0)
                return ST_INVALID;
            k = (n < TOP_COUNT) ? n : TOP_COUNT;
            for (int i = 0; i < k; i++)
                peak_sum += magnitude(top_vals[i]);
            if (OVER_NUM * peak_sum >= OVER_DEN * k * rated)
                return ST_OVER;
            if (peak_sum <= OFF_LIMIT_MA * k)
                return ST_OFF;
            if (peak_sum < minw * k)
                return ST_UNDER;
            return ST_NORMAL;
        end
        if (n == 0)
            return ST_INVALID;
        if (batch_mag_sum >= rated * n)
            return ST_OVER;
        if (batch_mag_sum >= minw * n)
            return ST_NORMAL;
        return ST_UNDER;
    endfunction

    // Update the predictor with one accepted sample beat.
    function automatic void classify_beat(logic [SAMPLE_W-1:0] raw, logic has, logic last);
        logic signed [SAMPLE_W-1:0] s;
        s = raw;
        if (has && batch_count < MAX_SAMPLES) begin
            rank_sample(s);
            batch_mag_sum += magnitude(s);
            batch_count++;
        end
        if (last) begin
            expected_status.insert(expected_status.size(), batch_status());
            batch_count = 0;
            batch_mag_sum = 0;
            for (int i = 0; i < TOP_COUNT; i++)
                top_vals[i] = '0;
        end
    endfunction

    // Offer one sample beat, with an occasional gap, until it is taken.
    task automatic send_beat(input logic [SAMPLE_W-1:0] sample, input logic has,
                             input logic last);
        while (!steady_run && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tuser  <= has;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        classify_beat(sample, has, last);
    endtask

    task automatic stop_stream();
        s_tvalid <= 1'b0;
    endtask

    // Wait for every outstanding status, then let the pipeline settle.
    task automatic wait_drained();
        while (expected_status.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // One register beat; the valid stays high for a following write.
    task automatic write_reg(input cfg_index_t idx, input logic [CUR_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_RATED: rated_ma = val;
            CFG_MINW:  min_work_ma = val;
            CFG_MODE:  mode_sel = val[0];
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [CUR_W-1:0] rated, input logic [CUR_W-1:0] minw,
                                input logic [CUR_W-1:0] mode_word);
        write_reg(CFG_MODE, mode_word);
        write_reg(CFG_RATED, rated);
        write_reg(CFG_MINW, minw);
        cfg_valid <= 1'b0;
    endtask

    // Peak mode with reset thresholds: each status and its boundaries.
    task automatic test_default_thresholds();
        send_beat(16'd900, 1'b1, 1'b0);
        send_beat(16'd950, 1'b1, 1'b0);
        send_beat(16'd1000, 1'b1, 1'b1);
        send_beat(16'h8000, 1'b1, 1'b0);
        send_beat(16'h7FFF, 1'b1, 1'b0);
        send_beat(16'd0, 1'b1, 1'b1);
        send_beat(16'd50, 1'b1, 1'b1);
        send_beat(16'd150, 1'b1, 1'b1);
        send_beat(16'd500, 1'b1, 1'b0);
        send_beat(16'hFFFF, 1'b1, 1'b0);
        send_beat(16'd400, 1'b1, 1'b1);
        // A batch made of one empty marker is invalid.
        send_beat(16'h5A5A, 1'b0, 1'b1);
        // Empty markers inside a batch add nothing.
        send_beat(16'd120, 1'b1, 1'b0);
        send_beat(16'hFFFF, 1'b0, 1'b0);
        send_beat(16'h7FFF, 1'b0, 1'b1);
        // Exactly four fifths of rated, exactly the off limit, exactly minimum.
        send_beat(16'd800, 1'b1, 1'b1);
        send_beat(16'd100, 1'b1, 1'b1);
        send_beat(16'd200, 1'b1, 1'b1);
        stop_stream();
        wait_drained();
    endtask

    // Zero and full-scale register values in both modes.
    task automatic test_register_extremes();
        write_config(16'd0, 16'd200, {15'd0, MODE_PEAK});
        send_beat(16'd500, 1'b1, 1'b1);
        stop_stream();
        wait_drained();
        write_config(16'd0, 16'd0, {15'd0, MODE_MEAN});
        send_beat(16'd0, 1'b1, 1'b1);
        send_beat(16'd0, 1'b0, 1'b1);
        stop_stream();
        wait_drained();
        write_config(16'hFFFF, 16'hFFFF, {15'h7FFF, MODE_MEAN});
        send_beat(16'h7FFF, 1'b1, 1'b0);
        send_beat(16'h8000, 1'b1, 1'b1);
        stop_stream();
        wait_drained();
        write_config(16'hFFFF, 16'd0, {15'd0, MODE_MEAN});
        send_beat(16'd0, 1'b1, 1'b1);
        stop_stream();
        wait_drained();
        write_config(16'hFFFF, 16'd0, {15'h5555, MODE_PEAK});
        send_beat(16'h8000, 1'b1, 1'b1);
        stop_stream();
        wait_drained();
        write_config(16'd1, 16'hFFFF, {15'd0, MODE_PEAK});
        send_beat(16'd1, 1'b1, 1'b1);
        stop_stream();
        wait_drained();
    endtask

    // Samples past the batch limit must not move the mean.
    task automatic test_full_batch();
        write_config(16'd1000, 16'd200, {15'd0, MODE_MEAN});
        for (int i = 0; i < MAX_SAMPLES + 6; i++)
            send_beat((i < MAX_SAMPLES) ? 16'd150 : 16'h7FFF, 1'b1,
                      i == MAX_SAMPLES + 5);
        stop_stream();
        wait_drained();
    endtask

    // The receiver stalls long enough for the block to refuse input.
    task automatic test_output_backpressure();
        write_config(16'd1000, 16'd200, {15'd0, MODE_PEAK});
        hold_req = 1'b1;
        for (int i = 0; i < 24; i++)
            send_beat(16'($urandom_range(1200)), 1'b1, 1'b1);
        stop_stream();
        wait_drained();
    endtask

    function automatic logic [CUR_W-1:0] pick_current();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(2000, 50));
        endcase
    endfunction

    // Mostly samples around the rated current, some fully random or near off.
    function automatic logic [SAMPLE_W-1:0] pick_sample(int unsigned scale);
        int unsigned m;
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 2)
            return 16'($urandom);
        if (pick < 3)
            m = $urandom_range(150);
        else
            m = $urandom_range(scale * 2);
        if (m > 32767)
            m = 32767;
        if ($urandom_range(3) == 0)
            return 16'(-int'(m));
        return 16'(m);
    endfunction

    // Random batches under several random register settings.
    task automatic test_random_batches();
        int sent;
        int nbeats;
        int unsigned scale;
        logic [CUR_W-1:0] rated;
        logic [CUR_W-1:0] minw;
        for (int phase = 0; phase < 6; phase++) begin
            steady_run = (phase == 1);
            rated = pick_current();
            minw = ($urandom_range(1) == 0) ? 16'($urandom_range(rated)) : pick_current();
            write_config(rated, minw, 16'($urandom));
            scale = (rated == 0) ? 1000 : rated;
            sent = 0;
            while (sent < 40) begin
                nbeats = ($urandom_range(9) == 0) ? $urandom_range(20, 9)
                                                  : $urandom_range(6, 1);
                for (int i = 0; i < nbeats; i++)
                    send_beat(pick_sample(scale), $urandom_range(99) >= 8,
                              i == nbeats - 1);
                sent += nbeats;
            end
            stop_stream();
            wait_drained();
        end
        steady_run = 1'b0;
    endtask

    // Receiver ready: random gaps, plus one long stall when requested.
    initial begin
        m_tready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= steady_run || ($urandom_range(99) >= 13);
                @(posedge aclk);
            end
        end
    end

    // Compare every status beat with the oldest expected status.
    always @(posedge aclk) begin
        status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_status.size() == 0) begin
                $error("pump_status: no status expected, actual %0d", m_tdata[STATUS_W-1:0]);
                fail_count++;
            end else begin
                want = expected_status.pop_front();
                if (m_tdata[STATUS_W-1:0] !== want) begin
                    $error("pump_status mismatch: expected %0d, actual %0d",
                           want, m_tdata[STATUS_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[TDATA_OUT_W-1:STATUS_W] !== '0) begin
                    $error("tdata padding mismatch: expected 0, actual %0d",
                           m_tdata[TDATA_OUT_W-1:STATUS_W]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_RATED;
        cfg_data = '0;
        rated_ma = RATED_RESET;
        min_work_ma = MINW_RESET;
        mode_sel = MODE_PEAK;
        batch_count = 0;
        batch_mag_sum = 0;
        for (int i = 0; i < TOP_COUNT; i++)
            top_vals[i] = '0;
        fail_count = 0;
        steady_run = 1'b0;
        hold_req = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_thresholds();
        test_register_extremes();
        test_full_batch();
        test_output_backpressure();
        test_random_batches();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/clc_pkg.sv
rtl/clc_front.sv
rtl/clc_queue.sv
rtl/clc_back.sv
rtl/current_level_classifier.sv
tb/current_level_classifier_tb.sv
